// ===== src/mrl_pkg.sv =====
// shared types, codes and helpers for the motor resistance/inductance identification core
// no dependencies
package mrl_pkg;

  // default parameter values
  localparam int unsigned STEP_BITS_DEF = 20;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // widths fixed by the field definitions
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned ADDR_W = 3;

  // configuration register indexes
  typedef enum logic [ADDR_W-1:0] {
    REG_IDLE_STEPS = 3'd0,
    REG_RES_STEPS  = 3'd1,
    REG_IND_STEPS  = 3'd2,
    REG_RES_CURR   = 3'd3,
    REG_IND_VOLT   = 3'd4,
    REG_PERIOD     = 3'd5
  } reg_idx_e;

  // routine stages
  localparam logic [2:0] STAGE_INIT  = 3'd0;
  localparam logic [2:0] STAGE_IDLE1 = 3'd1;
  localparam logic [2:0] STAGE_RES   = 3'd2;
  localparam logic [2:0] STAGE_IDLE2 = 3'd3;
  localparam logic [2:0] STAGE_IND   = 3'd4;
  localparam logic [2:0] STAGE_IDLE3 = 3'd5;
  localparam logic [2:0] STAGE_DONE  = 3'd6;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULK,
    ST_ACC,
    ST_DIV,
    ST_DIVEND,
    ST_MULV,
    ST_VT,
    ST_OUT
  } state_e;

  // what the running division is for
  typedef enum logic [1:0] {
    JOB_RES,
    JOB_AVG1,
    JOB_AVG2,
    JOB_IND
  } job_e;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = S32_MAX;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/motor_rl_identification_core.sv =====
// top level of the motor resistance/inductance identification core
// depends on mrl_pkg
//
// One control tick goes in as one word and gives one result word. Ticks in
// init, idle and done stages and inductance ticks go from acceptance straight
// to the output state; resistance ticks pass the multiply and accumulate states
// first. The last resistance tick runs one 64-step division (none when the
// current target is zero) and the last inductance tick runs three (two when the
// current delta is zero). The divisions use the single shared radix-2 divider,
// one quotient bit per cycle, beside one shared registered
// multiplier. The input is not ready while a tick is being worked; the finished
// result sits in an output register so the next tick can be taken while it
// waits, and a stalled result side adds its stall to the tick after. There is
// no clearing pass after reset.
module motor_rl_identification_core #(
  parameter int unsigned STEP_BITS = mrl_pkg::STEP_BITS_DEF,
  parameter int unsigned FRAC_BITS = mrl_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [mrl_pkg::ADDR_W-1:0] cfg_addr_i,
  input  logic [mrl_pkg::CFG_W-1:0]  cfg_wdata_i,
  // tick input
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // current_d [31:0], bus_voltage [62:32]
  input  logic [63:0]                s_axis_tdata_i,
  // result output
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // voltage_d_ref [31:0], drive_mode [32], routine_done [33], stage_now [36:34],
  // resistance [68:37], inductance [100:69], math_error [101]
  output logic [103:0]               m_axis_tdata_o
);
  import mrl_pkg::*;

  localparam int unsigned CNT_W = STEP_BITS + 1;
  localparam int unsigned SUM_W = STEP_BITS + 33;
  localparam logic signed [33:0] KI_GAIN = 34'((5 * (64'd1 << FRAC_BITS)) / 100);
  localparam logic [6:0] DIV_STEPS = 7'd64;

  // configuration registers
  logic [STEP_BITS-1:0] idle_cnt_q, res_cnt_q, ind_cnt_q;
  logic [CFG_W-1:0]     rtc_q, itv_q, per_q;

  // routine state
  state_e st_q, st_d;
  job_e   job_q, job_d;
  logic [2:0]              stage_q, stage_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [31:0]             integ_q, integ_d;
  logic                    sign_q, sign_d;
  logic signed [SUM_W-1:0] sum_lo_q, sum_lo_d, sum_hi_q, sum_hi_d;
  logic signed [31:0]      res_q, res_d, ind_q, ind_d;
  logic                    err_q, err_d;

  // working registers
  logic [CFG_W-1:0]   vbus_q, vbus_d;
  logic signed [33:0] diff_q, diff_d;
  logic signed [67:0] mul_q;
  logic signed [33:0] mul_a, mul_b;
  logic signed [63:0] avg1_q, avg1_d;

  // divider registers
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d, dden_q, dden_d;
  logic [6:0]  dcnt_q, dcnt_d;
  logic        dneg_q, dneg_d;
  logic               div_go;
  logic signed [63:0] div_num, div_den;

  // output register
  logic               ovalid_q, ovalid_d;
  logic signed [31:0] ovref_q, ovref_d, ores_q, ores_d, oind_q, oind_d;
  logic               omode_q, omode_d, odone_q, odone_d, oerr_q, oerr_d;
  logic [2:0]         ostage_q, ostage_d, pstage_q, pstage_d;
  logic signed [31:0] pvref_q, pvref_d;
  logic               pmode_q, pmode_d, pdone_q, pdone_d;

  // scratch
  logic                    in_acc;
  logic [CNT_W-1:0]        cnt_inc;
  logic signed [SUM_W-1:0] lo_n, hi_n;
  logic signed [64:0]      acc_sum;
  logic [31:0]             acc_val;
  logic [64:0]             rem_sh;
  logic signed [63:0]      quot, vt_sh;

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {2'b00, oerr_q, oind_q, ores_q, ostage_q, odone_q, omode_q, ovref_q};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cnt_q <= STEP_BITS'(1000);
      res_cnt_q  <= STEP_BITS'(1000);
      ind_cnt_q  <= STEP_BITS'(1000);
      rtc_q      <= CFG_W'(64'd1 << FRAC_BITS);
      itv_q      <= CFG_W'(64'd1 << FRAC_BITS);
      per_q      <= CFG_W'(7);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_IDLE_STEPS: idle_cnt_q <= cfg_wdata_i[STEP_BITS-1:0];
        REG_RES_STEPS:  res_cnt_q  <= cfg_wdata_i[STEP_BITS-1:0];
        REG_IND_STEPS:  ind_cnt_q  <= cfg_wdata_i[STEP_BITS-1:0];
        REG_RES_CURR:   rtc_q      <= cfg_wdata_i;
        REG_IND_VOLT:   itv_q      <= cfg_wdata_i;
        REG_PERIOD:     per_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    if (st_q == ST_MULV) begin
      mul_a = $signed({3'b000, itv_q});
      mul_b = $signed({3'b000, per_q});
    end else begin
      mul_a = KI_GAIN;
      mul_b = diff_q;
    end
  end

  // sequencer, datapath and divider next values
  always_comb begin
    st_d = st_q;  job_d = job_q;  stage_d = stage_q;  cnt_d = cnt_q;
    integ_d = integ_q;  sign_d = sign_q;  sum_lo_d = sum_lo_q;  sum_hi_d = sum_hi_q;
    res_d = res_q;  ind_d = ind_q;  err_d = err_q;
    vbus_d = vbus_q;  diff_d = diff_q;  avg1_d = avg1_q;
    rem_d = rem_q;  quo_d = quo_q;  dden_d = dden_q;  dcnt_d = dcnt_q;  dneg_d = dneg_q;
    pvref_d = pvref_q;  pmode_d = pmode_q;  pdone_d = pdone_q;  pstage_d = pstage_q;
    ovalid_d = ovalid_q;  ovref_d = ovref_q;  omode_d = omode_q;  odone_d = odone_q;
    ostage_d = ostage_q;  ores_d = ores_q;  oind_d = oind_q;  oerr_d = oerr_q;
    div_go = 1'b0;  div_num = '0;  div_den = 64'sd1;
    cnt_inc = cnt_q + CNT_W'(1);
    lo_n = sum_lo_q + SUM_W'($signed(s_axis_tdata_i[31:0]));
    hi_n = sum_hi_q + SUM_W'($signed(s_axis_tdata_i[31:0]));
    acc_sum = (cnt_q == '0) ? 65'sd0 : $signed({33'd0, integ_q});
    acc_sum = acc_sum + 65'(mul_q >>> FRAC_BITS);
    if (acc_sum > $signed({34'd0, vbus_q})) begin
      acc_val = {1'b0, vbus_q};
    end else if (acc_sum < 65'sd0) begin
      acc_val = '0;
    end else begin
      acc_val = acc_sum[31:0];
    end
    rem_sh = {rem_q, quo_q[63]};
    quot = dneg_q ? -$signed(quo_q) : $signed(quo_q);
    vt_sh = 64'(mul_q >>> FRAC_BITS) <<< FRAC_BITS;

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          vbus_d = s_axis_tdata_i[62:32];
          pstage_d = stage_q;  pvref_d = '0;  pmode_d = 1'b0;  pdone_d = 1'b0;
          st_d = ST_OUT;
          case (stage_q)
            STAGE_INIT: stage_d = STAGE_IDLE1;
            STAGE_IDLE1, STAGE_IDLE2, STAGE_IDLE3: begin
              if (cnt_inc > CNT_W'(idle_cnt_q)) begin
                cnt_d = '0;
                stage_d = stage_q + 3'd1;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            STAGE_RES: begin
              diff_d = $signed({3'b000, rtc_q}) - 34'($signed(s_axis_tdata_i[31:0]));
              st_d = ST_MULK;
            end
            STAGE_IND: begin
              if (sign_q) sum_lo_d = lo_n;
              else        sum_hi_d = hi_n;
              sign_d = !sign_q;
              pvref_d = !sign_q ? $signed({1'b0, itv_q}) : -$signed({1'b0, itv_q});
              pmode_d = 1'b1;
              cnt_d = cnt_inc;
              if (cnt_inc > CNT_W'(ind_cnt_q)) begin
                div_go = 1'b1;
                div_num = 64'(sign_q ? lo_n : sum_lo_q) <<< 1;
                div_den = $signed(64'(cnt_inc));
                job_d = JOB_AVG1;
                st_d = ST_DIV;
              end
            end
            default: pdone_d = 1'b1;
          endcase
        end
      end
      ST_MULK: st_d = ST_ACC;
      ST_ACC: begin
        integ_d = acc_val;
        pvref_d = $signed(acc_val);
        pmode_d = 1'b1;
        st_d = ST_OUT;
        if (cnt_inc > CNT_W'(res_cnt_q)) begin
          pvref_d = '0;  pmode_d = 1'b0;
          cnt_d = '0;
          stage_d = STAGE_IDLE2;
          if (rtc_q == '0) begin
            res_d = S32_MAX;
          end else begin
            div_go = 1'b1;
            div_num = $signed(64'(acc_val) << FRAC_BITS);
            div_den = $signed(64'(rtc_q));
            job_d = JOB_RES;
            st_d = ST_DIV;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, dden_q}) begin
          rem_d = 64'(rem_sh - {1'b0, dden_q});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh[63:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        dcnt_d = dcnt_q - 7'd1;
        if (dcnt_q == 7'd1) st_d = ST_DIVEND;
      end
      ST_DIVEND: begin
        case (job_q)
          JOB_RES: begin
            res_d = sat32(quot);
            st_d = ST_OUT;
          end
          JOB_AVG1: begin
            avg1_d = quot;
            div_go = 1'b1;
            div_num = 64'(sum_hi_q) <<< 1;
            div_den = $signed(64'(cnt_q));
            job_d = JOB_AVG2;
            st_d = ST_DIV;
          end
          JOB_AVG2: begin
            avg1_d = avg1_q - quot;
            st_d = ST_MULV;
          end
          default: begin
            ind_d = sat32(quot);
            err_d = 1'b0;
            st_d = ST_OUT;
          end
        endcase
      end
      ST_MULV: st_d = ST_VT;
      ST_VT: begin
        if (avg1_q == '0) begin
          err_d = 1'b1;
          st_d = ST_OUT;
        end else begin
          div_go = 1'b1;
          div_num = vt_sh;
          div_den = avg1_q;
          job_d = JOB_IND;
          st_d = ST_DIV;
        end
      end
      default: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          ovref_d = pvref_q;  omode_d = pmode_q;  odone_d = pdone_q;  ostage_d = pstage_q;
          ores_d = res_q;  oind_d = ind_q;  oerr_d = err_q;
          st_d = ST_IDLE;
        end
      end
    endcase

    // end of inductance stage: clean up once the last division is launched or skipped, and again when it finishes
    if ((st_q == ST_VT) || (st_q == ST_DIVEND && job_q == JOB_IND)) begin
      pvref_d = '0;  pmode_d = 1'b0;
      cnt_d = '0;  stage_d = STAGE_IDLE3;  sign_d = 1'b1;
      sum_lo_d = '0;  sum_hi_d = '0;
    end

    // load the divider with magnitudes
    if (div_go) begin
      rem_d = '0;
      quo_d = div_num[63] ? 64'(-div_num) : 64'(div_num);
      dden_d = div_den[63] ? 64'(-div_den) : 64'(div_den);
      dneg_d = div_num[63] ^ div_den[63];
      dcnt_d = DIV_STEPS;
    end
  end

  // state and data registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;  job_q <= JOB_RES;  stage_q <= STAGE_INIT;  cnt_q <= '0;
      integ_q <= '0;  sign_q <= 1'b1;  sum_lo_q <= '0;  sum_hi_q <= '0;
      res_q <= '0;  ind_q <= '0;  err_q <= 1'b0;
      dcnt_q <= '0;  ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;  job_q <= job_d;  stage_q <= stage_d;  cnt_q <= cnt_d;
      integ_q <= integ_d;  sign_q <= sign_d;  sum_lo_q <= sum_lo_d;  sum_hi_q <= sum_hi_d;
      res_q <= res_d;  ind_q <= ind_d;  err_q <= err_d;
      dcnt_q <= dcnt_d;  ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vbus_q <= vbus_d;  diff_q <= diff_d;  avg1_q <= avg1_d;
    mul_q <= mul_a * mul_b;
    rem_q <= rem_d;  quo_q <= quo_d;  dden_q <= dden_d;  dneg_q <= dneg_d;
    pvref_q <= pvref_d;  pmode_q <= pmode_d;  pdone_q <= pdone_d;  pstage_q <= pstage_d;
    ovref_q <= ovref_d;  omode_q <= omode_d;  odone_q <= odone_d;  ostage_q <= ostage_d;
    ores_q <= ores_d;  oind_q <= oind_d;  oerr_q <= oerr_d;
  end

  // checks
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (dden_q != '0))
    else $error("divider running with zero divisor");
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (dcnt_q != '0))
    else $error("divider step count exhausted");
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q <= STAGE_DONE))
    else $error("stage code beyond the done stage reached");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT && st_d == ST_IDLE) |=> ovalid_q)
    else $error("result word lost on load");
endmodule
